// ===== design/dtpc_pkg.sv =====
// dtpc_pkg: shared types and constants for the disparity to point cloud block.
// Depends on nothing; used by dtpc_frame_store, dtpc_divider and the top level.
package dtpc_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);

  // field widths
  localparam int COORD_W = 10;
  localparam int DISP_W  = 16;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 21;
  localparam int REG_IDX_W = 3;

  // arithmetic widths
  localparam int MUL_OP_W   = 21;
  localparam int PROD_W     = 2 * MUL_OP_W;
  localparam int DIVIDEND_W = 41;
  localparam int DIVISOR_W  = 18;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_REPROJECT = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FOCAL       = 3'd0,
    REG_BASELINE    = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_CENTER_DIFF = 3'd4,
    REG_MAX_DEPTH   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_DIVGO,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    LANE_Z,
    LANE_X,
    LANE_Y
  } lane_t;

  typedef struct packed {
    logic [DISP_W-1:0]  disp;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } store_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/dtpc_frame_store.sv =====
// dtpc_frame_store: one-port frame memory holding disparity and colour per pixel.
// Depends on dtpc_pkg for the entry type and address width.
module dtpc_frame_store (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [dtpc_pkg::ADDR_W-1:0]  addr,
  input  dtpc_pkg::store_entry_t       wdata,
  output dtpc_pkg::store_entry_t       rdata
);

  dtpc_pkg::store_entry_t mem [0:dtpc_pkg::FRAME_PIXELS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== design/dtpc_divider.sv =====
// dtpc_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on dtpc_pkg for widths and the status struct.
module dtpc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dtpc_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [dtpc_pkg::DIVISOR_W-1:0]   divisor,
  output logic [dtpc_pkg::DIVIDEND_W-1:0]  quotient,
  output dtpc_pkg::div_stat_t              stat
);

  localparam int DW = dtpc_pkg::DIVIDEND_W;
  localparam int VW = dtpc_pkg::DIVISOR_W;

  logic [VW-1:0]                  rem;
  logic [VW-1:0]                  dvs;
  logic [dtpc_pkg::DIV_CNT_W-1:0] cnt;
  logic [VW:0]                    trial;
  logic [VW+1:0]                  diff;
  logic                           qbit;
  logic [VW-1:0]                  rem_next;

  always_comb begin
    trial    = {rem, quotient[DW-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    qbit     = ~diff[VW+1];
    rem_next = qbit ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= dtpc_pkg::DIV_CNT_W'(DW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == dtpc_pkg::DIV_CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (stat.busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DW-2:0], qbit};
    end
  end

endmodule

// ===== design/disparity_to_point_cloud.sv =====
// disparity_to_point_cloud: load pixels into a frame store, reproject stored pixels to 3D.
// Depends on dtpc_pkg, dtpc_frame_store and dtpc_divider.
// Load word: busy stays low. Reproject word: the result strobe is registered after the
// fetch state for out-of-frame or rejected pixels, after the Z division for a depth
// reject, and after the Z, X and Y divisions (41-step divider each) for a kept point.
// A new word is taken in the cycle the result strobe shows. rst (synchronous) clears
// control, frame minimum and registers; the frame store itself is not cleared.
module disparity_to_point_cloud (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [dtpc_pkg::COORD_W-1:0]        col,
  input  logic [dtpc_pkg::COORD_W-1:0]        row,
  input  logic signed [dtpc_pkg::DISP_W-1:0]  disparity,
  input  logic [dtpc_pkg::COLOR_W-1:0]        blue,
  input  logic [dtpc_pkg::COLOR_W-1:0]        green,
  input  logic [dtpc_pkg::COLOR_W-1:0]        red,
  // configuration write port
  input  logic                                wr_en,
  input  logic [dtpc_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [dtpc_pkg::CFG_W-1:0]          wr_data,
  // result
  output logic                                done,
  output logic                                point_valid,
  output logic signed [dtpc_pkg::POS_W-1:0]   pos_x,
  output logic signed [dtpc_pkg::POS_W-1:0]   pos_y,
  output logic signed [dtpc_pkg::POS_W-1:0]   pos_z,
  output logic [dtpc_pkg::COLOR_W-1:0]        out_red,
  output logic [dtpc_pkg::COLOR_W-1:0]        out_green,
  output logic [dtpc_pkg::COLOR_W-1:0]        out_blue
);

  localparam int PW = dtpc_pkg::PROD_W;
  localparam int DW = dtpc_pkg::DIVIDEND_W;
  localparam int VW = dtpc_pkg::DIVISOR_W;
  localparam int OW = dtpc_pkg::MUL_OP_W;
  localparam int SW = dtpc_pkg::POS_W;

  // ---------------- configuration registers ----------------
  logic [19:0]        focal_length;
  logic signed [20:0] baseline;
  logic [15:0]        center_x;
  logic [15:0]        center_y;
  logic signed [16:0] center_diff;
  logic [19:0]        max_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length <= '0;
      baseline     <= '0;
      center_x     <= '0;
      center_y     <= '0;
      center_diff  <= '0;
      max_depth    <= 20'd32000;
    end else if (wr_en) begin
      unique case (dtpc_pkg::reg_idx_t'(wr_index))
        dtpc_pkg::REG_FOCAL:       focal_length <= wr_data[19:0];
        dtpc_pkg::REG_BASELINE:    baseline     <= $signed(wr_data[20:0]);
        dtpc_pkg::REG_CENTER_X:    center_x     <= wr_data[15:0];
        dtpc_pkg::REG_CENTER_Y:    center_y     <= wr_data[15:0];
        dtpc_pkg::REG_CENTER_DIFF: center_diff  <= $signed(wr_data[16:0]);
        dtpc_pkg::REG_MAX_DEPTH:   max_depth    <= wr_data[19:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- sequencer ----------------
  dtpc_pkg::state_t state, state_next;
  dtpc_pkg::lane_t  lane;

  logic accept;
  logic in_frame;
  logic [dtpc_pkg::ADDR_W-1:0] addr;

  logic store_en;
  logic store_we;
  logic div_start;
  dtpc_pkg::store_entry_t wr_entry;
  dtpc_pkg::store_entry_t rd_entry;

  logic                         inside_q;
  logic [dtpc_pkg::COORD_W-1:0] col_q;
  logic [dtpc_pkg::COORD_W-1:0] row_q;
  logic signed [dtpc_pkg::DISP_W-1:0] frame_min;

  // fetch-cycle checks on the stored pixel
  logic signed [VW-1:0] den;
  logic [VW-1:0]        den_abs_w;
  logic                 skip;
  logic [VW-1:0]        den_abs;
  logic                 den_neg;

  // shared multiplier and its operand select
  logic signed [OW-1:0] mul_a;
  logic signed [17:0]   off_x;
  logic signed [17:0]   off_y;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        prod_abs;
  logic                 q_neg;

  logic [DW-1:0]        quotient;
  dtpc_pkg::div_stat_t  div_stat;
  logic signed [SW-1:0] q_sat;
  logic                 depth_fail;

  assign accept   = start && !busy;
  assign in_frame = (col < dtpc_pkg::FRAME_WIDTH) && (row < dtpc_pkg::FRAME_HEIGHT);
  assign addr     = dtpc_pkg::ADDR_W'(row * dtpc_pkg::FRAME_WIDTH + col);
  assign wr_entry = '{disp: disparity, red: red, green: green, blue: blue};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dtpc_pkg::ST_IDLE: begin
        if (accept && opcode == dtpc_pkg::OP_REPROJECT) state_next = dtpc_pkg::ST_FETCH;
      end
      dtpc_pkg::ST_FETCH: begin
        state_next = (!inside_q || skip) ? dtpc_pkg::ST_IDLE : dtpc_pkg::ST_MUL;
      end
      dtpc_pkg::ST_MUL:   state_next = dtpc_pkg::ST_DIVGO;
      dtpc_pkg::ST_DIVGO: state_next = dtpc_pkg::ST_DIV;
      dtpc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if ((lane == dtpc_pkg::LANE_Z && depth_fail) || lane == dtpc_pkg::LANE_Y) begin
            state_next = dtpc_pkg::ST_IDLE;
          end else begin
            state_next = dtpc_pkg::ST_MUL;
          end
        end
      end
      default: state_next = dtpc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = (state != dtpc_pkg::ST_IDLE);
    div_start = (state == dtpc_pkg::ST_DIVGO);
    store_en  = accept && in_frame;
    store_we  = (opcode == dtpc_pkg::OP_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  dtpc_frame_store u_store (
    .clk   (clk),
    .en    (store_en),
    .we    (store_we),
    .addr  (addr),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  // ---------------- datapath ----------------
  always_comb begin
    den = $signed({center_diff[16], center_diff})
        - $signed({{(VW - dtpc_pkg::DISP_W){rd_entry.disp[dtpc_pkg::DISP_W-1]}}, rd_entry.disp});
    den_abs_w = den[VW-1] ? VW'(-den) : VW'(den);
    skip = (rd_entry.disp == '0) || ($signed(rd_entry.disp) == frame_min) || (den == '0);
  end

  // pixel offsets in 1/16 pixel: 16*col - cx
  assign off_x = $signed({4'b0000, col_q, 4'b0000}) - $signed({2'b00, center_x});
  assign off_y = $signed({4'b0000, row_q, 4'b0000}) - $signed({2'b00, center_y});

  always_comb begin
    case (lane)
      dtpc_pkg::LANE_X: mul_a = {{(OW - 18){off_x[17]}}, off_x};
      dtpc_pkg::LANE_Y: mul_a = {{(OW - 18){off_y[17]}}, off_y};
      default:          mul_a = $signed({1'b0, focal_length});
    endcase
  end

  assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);

  dtpc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[DW-1:0]),
    .divisor  (den_abs),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // sign and saturate the quotient magnitude to 32 bits
  always_comb begin
    if (!q_neg) begin
      q_sat = (|quotient[DW-1:SW-1]) ? {1'b0, {(SW-1){1'b1}}} : $signed(quotient[SW-1:0]);
    end else if ((|quotient[DW-1:SW]) || (quotient[SW-1] && (|quotient[SW-2:0]))) begin
      q_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      q_sat = $signed(-quotient[SW-1:0]);
    end
    depth_fail = (quotient >= {{(DW - 20){1'b0}}, max_depth});
  end

  // control registers: frame minimum, lane, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_min <= '0;
      lane      <= dtpc_pkg::LANE_Z;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept && opcode == dtpc_pkg::OP_LOAD && in_frame) begin
        if ((col == '0 && row == '0) || (disparity < frame_min)) frame_min <= disparity;
      end
      if (state == dtpc_pkg::ST_FETCH) begin
        lane <= dtpc_pkg::LANE_Z;
        if (!inside_q || skip) done <= 1'b1;
      end
      if (state == dtpc_pkg::ST_DIV && div_stat.done) begin
        unique case (lane)
          dtpc_pkg::LANE_Z: begin
            if (depth_fail) done <= 1'b1;
            else            lane <= dtpc_pkg::LANE_X;
          end
          dtpc_pkg::LANE_X: lane <= dtpc_pkg::LANE_Y;
          dtpc_pkg::LANE_Y: done <= 1'b1;
          default:          lane <= dtpc_pkg::LANE_Z;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      inside_q <= in_frame;
      col_q    <= col;
      row_q    <= row;
    end
    if (state == dtpc_pkg::ST_FETCH) begin
      den_abs     <= den_abs_w;
      den_neg     <= den[VW-1];
      point_valid <= 1'b0;
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      out_red     <= inside_q ? rd_entry.red   : '0;
      out_green   <= inside_q ? rd_entry.green : '0;
      out_blue    <= inside_q ? rd_entry.blue  : '0;
    end
    if (state == dtpc_pkg::ST_MUL) begin
      prod <= mul_a * baseline;
    end
    if (state == dtpc_pkg::ST_DIVGO) begin
      q_neg <= prod[PW-1] ^ den_neg;
    end
    if (state == dtpc_pkg::ST_DIV && div_stat.done) begin
      case (lane)
        dtpc_pkg::LANE_Z: begin
          if (!depth_fail) pos_z <= q_sat;
        end
        dtpc_pkg::LANE_X: pos_x <= q_sat;
        default: begin
          pos_y       <= q_sat;
          point_valid <= 1'b1;
        end
      endcase
    end
  end

  // ---------------- checks ----------------
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
      (accept && opcode == dtpc_pkg::OP_LOAD) |=> !busy)
    else $error("load word left the sequencer busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_stat.busy)
    else $error("divider restarted while running");

  a_depth_ok: assert property (@(posedge clk) disable iff (rst)
      (done && point_valid) |->
      (pos_z < $signed({12'b0, max_depth})) && (pos_z > -$signed({12'b0, max_depth})))
    else $error("kept point beyond depth limit");

endmodule
